// ===== rtl/core/three_level_ready_queue_scheduler_macros.svh =====
// Assertion macros for the ready-queue scheduler RTL.
// Included by the modules that carry concurrent assertions.
`ifndef THREE_LEVEL_READY_QUEUE_SCHEDULER_MACROS_SVH
`define THREE_LEVEL_READY_QUEUE_SCHEDULER_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TLRQ_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("tlrq assertion failed");
`define TLRQ_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("tlrq forbidden condition");
`else
`define TLRQ_ASSERT(label, clk, rst_n, prop)
`define TLRQ_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/core/tlrq_pkg.sv =====
// Shared types, codes and key function for the ready-queue scheduler.
// No dependencies.
`default_nettype none
package tlrq_pkg;
	localparam int MAX_THREADS = 16;
	localparam int RANK_W = $clog2(MAX_THREADS);
	localparam int CNT_W = $clog2(MAX_THREADS + 1);
	localparam int KEY_W = 1 + 2 + 16 + RANK_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_DEQUEUE = 2'd1,
		CMD_CHECK   = 2'd2,
		CMD_AGE     = 2'd3
	} cmd_e;

	localparam logic [1:0] LVL_1 = 2'd0;
	localparam logic [1:0] LVL_2 = 2'd1;
	localparam logic [1:0] LVL_3 = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_L1_FLOOR     = 3'd0,
		REG_L2_FLOOR     = 3'd1,
		REG_AGING_WAIT   = 3'd2,
		REG_AGING_STEP   = 3'd3,
		REG_PRIORITY_CAP = 3'd4
	} reg_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_AGE_WAIT,
		ST_AGE_BOOST,
		ST_SORT
	} state_e;

	typedef enum logic [2:0] {
		OP_HOLD,
		OP_ENQ,
		OP_DEQ,
		OP_AGE_WAIT,
		OP_AGE_BOOST,
		OP_SORT_EVEN,
		OP_SORT_ODD
	} cell_op_e;

	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  thread_tag;
		logic [7:0]  thread_priority;
		logic [15:0] burst_estimate;
		logic [31:0] now_tick;
		logic [7:0]  running_priority;
		logic [15:0] running_burst;
	} in_t;

	typedef struct packed {
		logic       found;
		logic [7:0] chosen_tag;
		logic [1:0] chosen_level;
		logic       preempt;
		logic       table_full;
	} out_t;

	typedef struct packed {
		logic [7:0]  l1_floor;
		logic [7:0]  l2_floor;
		logic [15:0] aging_wait;
		logic [7:0]  aging_step;
		logic [7:0]  priority_cap;
	} cfg_t;

	typedef struct packed {
		logic              used;
		logic [7:0]        tag;
		logic [7:0]        prio;
		logic [15:0]       burst;
		logic [31:0]       wait_start;
		logic [31:0]       wait_total;
		logic [1:0]        level;
		logic [RANK_W-1:0] rank;
	} entry_t;

	typedef struct packed {
		cell_op_e          op;
		entry_t            ins;
		logic [31:0]       now;
		cfg_t              cfg;
		logic [RANK_W-1:0] head_rank;
	} cell_ctl_t;

	// visit order: used first, then level, then the level's own key, then rank
	// free entries all share the largest key, whatever their stale contents
	function automatic logic [KEY_W-1:0] sort_key(input entry_t e);
		logic [15:0] k;
		begin
			if (!e.used) begin
				return '1;
			end
			if (e.level == LVL_1) begin
				k = e.burst;
			end else if (e.level == LVL_2) begin
				k = {8'h00, ~e.prio};
			end else begin
				k = 16'h0000;
			end
			return {~e.used, e.level, k, e.rank};
		end
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/three_level_ready_queue_scheduler.sv =====
// Enqueue, dequeue and preemption check: result registered at the accepting
// edge, next transaction accepted once out_ready takes the held result; one chain
// operation per command. Age: wait update at the accepting edge, a boost step
// and MAX_THREADS + 1 odd-even sort phases.
// Reset empties the table and loads register defaults; no clearing pass.
// Depends on tlrq_pkg, tlrq_cell and the macros header.
`default_nettype none
`include "three_level_ready_queue_scheduler_macros.svh"
module three_level_ready_queue_scheduler import tlrq_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_t                   in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_t                       out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);
	cfg_t                 cfg_q;
	state_e               state_q, state_d;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     phase_q;
	logic                 out_valid_q;
	out_t                 out_q, out_d;
	logic                 out_load;
	logic                 accept;
	logic                 full;
	logic                 pre;
	logic                 sort_last;
	cell_ctl_t            ctl;
	entry_t               ins;
	entry_t               head;
	entry_t               cell_e [MAX_THREADS];
	entry_t               prev_e [MAX_THREADS];
	entry_t               next_e [MAX_THREADS];
	logic [MAX_THREADS-1:0] lt_v, swap_v, prev_lt_v, prev_swap_v, used_vec;

	assign accept = in_valid && in_ready;
	assign head = cell_e[0];
	assign full = cell_e[MAX_THREADS-1].used;
	assign sort_last = (phase_q == CNT_W'(MAX_THREADS - 1));
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.l1_floor <= 8'd100;
			cfg_q.l2_floor <= 8'd50;
			cfg_q.aging_wait <= 16'd1500;
			cfg_q.aging_step <= 8'd10;
			cfg_q.priority_cap <= 8'd149;
		end else if (cfg_we) begin
			unique case (reg_e'(cfg_index))
				REG_L1_FLOOR:     cfg_q.l1_floor <= cfg_wdata[7:0];
				REG_L2_FLOOR:     cfg_q.l2_floor <= cfg_wdata[7:0];
				REG_AGING_WAIT:   cfg_q.aging_wait <= cfg_wdata;
				REG_AGING_STEP:   cfg_q.aging_step <= cfg_wdata[7:0];
				REG_PRIORITY_CAP: cfg_q.priority_cap <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		ins.used = 1'b1;
		ins.tag = in_data.thread_tag;
		ins.prio = in_data.thread_priority;
		ins.burst = in_data.burst_estimate;
		ins.wait_start = in_data.now_tick;
		ins.wait_total = 32'h0;
		ins.rank = cnt_q[RANK_W-1:0];
		if (in_data.thread_priority >= cfg_q.l1_floor) begin
			ins.level = LVL_1;
		end else if (in_data.thread_priority >= cfg_q.l2_floor) begin
			ins.level = LVL_2;
		end else begin
			ins.level = LVL_3;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && cmd_e'(in_data.command) == CMD_AGE) begin
					state_d = ST_AGE_WAIT;
				end
			end
			ST_AGE_WAIT:  state_d = ST_AGE_BOOST;
			ST_AGE_BOOST: state_d = ST_SORT;
			ST_SORT: begin
				if (sort_last) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl.op = OP_HOLD;
		ctl.ins = ins;
		ctl.now = in_data.now_tick;
		ctl.cfg = cfg_q;
		ctl.head_rank = head.rank;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (cmd_e'(in_data.command))
						CMD_ENQUEUE: begin
							out_load = 1'b1;
							if (!full) begin
								ctl.op = OP_ENQ;
							end
						end
						CMD_DEQUEUE: begin
							out_load = 1'b1;
							if (head.used) begin
								ctl.op = OP_DEQ;
							end
						end
						CMD_CHECK: out_load = 1'b1;
						default: ctl.op = OP_AGE_WAIT;
					endcase
				end
			end
			ST_AGE_WAIT:  ctl.op = OP_AGE_BOOST;
			ST_AGE_BOOST: ctl.op = OP_SORT_EVEN;
			ST_SORT: begin
				ctl.op = phase_q[0] ? OP_SORT_EVEN : OP_SORT_ODD;
				out_load = sort_last;
			end
			default: ctl.op = OP_HOLD;
		endcase
	end

	always_comb begin
		pre = 1'b0;
		if (head.used && head.level == LVL_1) begin
			pre = (in_data.running_priority < cfg_q.l1_floor)
				|| (in_data.running_burst > head.burst);
		end else if (head.used) begin
			pre = in_data.running_priority < cfg_q.l2_floor;
		end
		out_d = '0;
		if (state_q == ST_IDLE) begin
			unique case (cmd_e'(in_data.command))
				CMD_ENQUEUE: out_d.table_full = full;
				CMD_DEQUEUE: begin
					out_d.found = head.used;
					out_d.chosen_tag = head.used ? head.tag : 8'h00;
					out_d.chosen_level = head.used ? head.level : LVL_1;
				end
				CMD_CHECK: out_d.preempt = pre;
				default: out_d = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			phase_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.op == OP_ENQ) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (ctl.op == OP_DEQ) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (state_q == ST_SORT && !sort_last) begin
				phase_q <= phase_q + CNT_W'(1);
			end else begin
				phase_q <= '0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= out_d;
		end
	end

	for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
		if (i == 0) begin : g_first
			assign prev_e[i] = '0;
			assign prev_lt_v[i] = 1'b0;
			assign prev_swap_v[i] = 1'b0;
		end else begin : g_mid
			assign prev_e[i] = cell_e[i-1];
			assign prev_lt_v[i] = lt_v[i-1];
			assign prev_swap_v[i] = swap_v[i-1];
		end
		if (i == MAX_THREADS - 1) begin : g_last
			assign next_e[i] = '0;
		end else begin : g_inner
			assign next_e[i] = cell_e[i+1];
		end
		assign used_vec[i] = cell_e[i].used;

		tlrq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.pos        (RANK_W'(i)),
			.prev_entry (prev_e[i]),
			.next_entry (next_e[i]),
			.prev_lt    (prev_lt_v[i]),
			.prev_swap  (prev_swap_v[i]),
			.lt         (lt_v[i]),
			.swap       (swap_v[i]),
			.entry      (cell_e[i])
		);
	end

	`TLRQ_ASSERT(a_count_matches, clk, arst_n, $countones(used_vec) == cnt_q)
	`TLRQ_ASSERT(a_used_packed, clk, arst_n, $onehot({1'b0, used_vec} + (MAX_THREADS + 1)'(1)))
	`TLRQ_NEVER(a_busy_no_accept, clk, arst_n, state_q != ST_IDLE && in_ready)
	`TLRQ_ASSERT(a_empty_deq, clk, arst_n, accept && cmd_e'(in_data.command) == CMD_DEQUEUE && !head.used |=> out_valid && !out_data.found)
	`TLRQ_NEVER(a_load_clobber, clk, arst_n, state_q == ST_SORT && sort_last && out_valid_q)
endmodule
`default_nettype wire

// ===== rtl/core/tlrq_cell.sv =====
// One cell of the sorted ready-queue chain: holds one entry.
// Depends on tlrq_pkg.
`default_nettype none
module tlrq_cell import tlrq_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cell_ctl_t         ctl,
	input  wire logic [RANK_W-1:0] pos,
	input  wire entry_t            prev_entry,
	input  wire entry_t            next_entry,
	input  wire logic              prev_lt,
	input  wire logic              prev_swap,
	output logic                   lt,
	output logic                   swap,
	output entry_t                 entry
);
	logic   used_q;
	entry_t data_q;
	entry_t cur;
	entry_t entry_d;
	logic   pair_start;
	logic [8:0] np;
	logic [7:0] np_sat;

	always_comb begin
		cur = data_q;
		cur.used = used_q;
	end

	assign entry = cur;
	assign lt = sort_key(ctl.ins) < sort_key(cur);
	assign pair_start = (ctl.op == OP_SORT_ODD) ? pos[0] : ~pos[0];
	assign swap = (ctl.op == OP_SORT_EVEN || ctl.op == OP_SORT_ODD) && pair_start
		&& (sort_key(cur) > sort_key(next_entry));
	assign np = {1'b0, cur.prio} + {1'b0, ctl.cfg.aging_step};
	assign np_sat = np[8] ? 8'hFF : np[7:0];

	always_comb begin
		entry_d = cur;
		case (ctl.op)
			OP_ENQ: begin
				if (prev_lt) begin
					entry_d = prev_entry;
				end else if (lt) begin
					entry_d = ctl.ins;
				end
			end
			OP_DEQ: begin
				entry_d = next_entry;
				if (next_entry.rank > ctl.head_rank) begin
					entry_d.rank = next_entry.rank - RANK_W'(1);
				end
			end
			OP_AGE_WAIT: begin
				entry_d.wait_total = ctl.now - cur.wait_start + cur.wait_total;
				entry_d.wait_start = ctl.now;
				entry_d.rank = pos;
			end
			OP_AGE_BOOST: begin
				if (cur.used && cur.wait_total >= {16'h0000, ctl.cfg.aging_wait}) begin
					entry_d.wait_total = cur.wait_total - {16'h0000, ctl.cfg.aging_wait};
					if (cur.level == LVL_1) begin
						if (np <= {1'b0, ctl.cfg.priority_cap}) begin
							entry_d.prio = np[7:0];
						end
					end else begin
						entry_d.prio = np_sat;
						if (cur.level == LVL_2 && np_sat >= ctl.cfg.l1_floor) begin
							entry_d.level = LVL_1;
						end else if (cur.level == LVL_3 && np_sat >= ctl.cfg.l2_floor) begin
							entry_d.level = LVL_2;
						end
					end
				end
			end
			OP_SORT_EVEN, OP_SORT_ODD: begin
				if (swap) begin
					entry_d = next_entry;
				end else if (prev_swap) begin
					entry_d = prev_entry;
				end
			end
			default: begin
				entry_d = cur;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else begin
			used_q <= entry_d.used;
		end
	end

	always_ff @(posedge clk) begin
		data_q <= entry_d;
	end
endmodule
`default_nettype wire

// ===== bench/three_level_ready_queue_scheduler_tb.sv =====
// Self-checking bench for the three-level ready-queue scheduler.
// Predicts each result from a behavioral copy of the slot table and checks it in order.
// Depends on tlrq_pkg and the scheduler RTL.
`default_nettype none
module three_level_ready_queue_scheduler_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tlrq_pkg::*;

	class sched_scoreboard;
		bit          used [16];
		bit [7:0]    tag [16];
		bit [7:0]    prio [16];
		bit [15:0]   burst [16];
		bit [31:0]   wstart [16];
		bit [31:0]   wtotal [16];
		bit [1:0]    lvl [16];
		bit [15:0]   rank [16];
		bit [15:0]   next_rank;
		bit [7:0]    l1f, l2f, step, cap;
		bit [15:0]   wait_ticks;
		out_t        pending[$];
		int          errors;

		function void clear();
			foreach (used[i]) used[i] = 0;
			next_rank = 0;
			l1f = 100; l2f = 50; wait_ticks = 1500; step = 10; cap = 149;
			pending.delete();
			errors = 0;
		endfunction

		function void write_reg(reg_e idx, bit [15:0] v);
			case (idx)
				REG_L1_FLOOR: l1f = v[7:0];
				REG_L2_FLOOR: l2f = v[7:0];
				REG_AGING_WAIT: wait_ticks = v;
				REG_AGING_STEP: step = v[7:0];
				REG_PRIORITY_CAP: cap = v[7:0];
				default: ;
			endcase
		endfunction

		function bit ahead(bit [1:0] l, int a, int b);
			if (l == LVL_1 && burst[a] != burst[b]) return burst[a] < burst[b];
			if (l == LVL_2 && prio[a] != prio[b]) return prio[a] > prio[b];
			return rank[a] < rank[b];
		endfunction

		function int head_of(bit [1:0] l, bit skip [16]);
			int best;
			best = -1;
			for (int i = 0; i < 16; i++)
				if (used[i] && lvl[i] == l && !skip[i])
					if (best < 0 || ahead(l, i, best)) best = i;
			return best;
		endfunction

		function void age_table(bit [31:0] now);
			bit skip [16];
			int order_q[$];
			int s;
			bit [31:0] tot;
			bit [8:0] np;
			foreach (skip[i]) skip[i] = 0;
			for (int l = 0; l < 3; l++) begin
				s = head_of(l[1:0], skip);
				while (s >= 0) begin
					skip[s] = 1;
					order_q.push_back(s);
					s = head_of(l[1:0], skip);
				end
			end
			foreach (order_q[k]) begin
				s = order_q[k];
				rank[s] = k[15:0];
				tot = now - wstart[s] + wtotal[s];
				wstart[s] = now;
				if (tot >= {16'h0, wait_ticks}) begin
					tot -= {16'h0, wait_ticks};
					np = {1'b0, prio[s]} + {1'b0, step};
					if (lvl[s] == LVL_1) begin
						if (np <= {1'b0, cap}) prio[s] = np[7:0];
					end else begin
						if (np > 9'd255) np = 9'd255;
						prio[s] = np[7:0];
						if (lvl[s] == LVL_2 && np >= {1'b0, l1f}) lvl[s] = LVL_1;
						else if (lvl[s] == LVL_3 && np >= {1'b0, l2f}) lvl[s] = LVL_2;
					end
				end
				wtotal[s] = tot;
			end
			next_rank = 16'(order_q.size());
		endfunction

		function void note_command(in_t t);
			out_t r;
			bit none [16];
			int s;
			r = '0;
			foreach (none[i]) none[i] = 0;
			case (cmd_e'(t.command))
				CMD_ENQUEUE: begin
					s = -1;
					for (int i = 0; i < 16; i++)
						if (!used[i] && s < 0) s = i;
					if (s < 0) r.table_full = 1;
					else begin
						used[s] = 1; tag[s] = t.thread_tag; prio[s] = t.thread_priority;
						burst[s] = t.burst_estimate; wstart[s] = t.now_tick; wtotal[s] = 0;
						lvl[s] = t.thread_priority >= l1f ? LVL_1 :
							(t.thread_priority >= l2f ? LVL_2 : LVL_3);
						rank[s] = next_rank;
						next_rank++;
					end
				end
				CMD_DEQUEUE: begin
					s = head_of(LVL_1, none);
					if (s < 0) s = head_of(LVL_2, none);
					if (s < 0) s = head_of(LVL_3, none);
					if (s >= 0) begin
						r.found = 1; r.chosen_tag = tag[s]; r.chosen_level = lvl[s];
						used[s] = 0;
						for (int i = 0; i < 16; i++)
							if (used[i] && rank[i] > rank[s]) rank[i]--;
						if (next_rank > 0) next_rank--;
					end
				end
				CMD_CHECK: begin
					s = head_of(LVL_1, none);
					if (s >= 0)
						r.preempt = t.running_priority < l1f || t.running_burst > burst[s];
					else
						r.preempt = (head_of(LVL_2, none) >= 0 || head_of(LVL_3, none) >= 0)
							&& t.running_priority < l2f;
				end
				default: age_table(t.now_tick);
			endcase
			pending.push_back(r);
		endfunction

		function void check_result(out_t got);
			out_t exp_r;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, got);
				errors++;
				return;
			end
			exp_r = pending.pop_front();
			if (got.found !== exp_r.found || got.chosen_tag !== exp_r.chosen_tag ||
				got.chosen_level !== exp_r.chosen_level ||
				got.preempt !== exp_r.preempt || got.table_full !== exp_r.table_full) begin
				$display("%0t: mismatch expected %h actual %h", $realtime, exp_r, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	in_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	out_t out_data;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	sched_scoreboard sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit [31:0] tick_now = 0;

	three_level_ready_queue_scheduler dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_result(out_data);
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	task automatic send_cmd(cmd_e c, bit [7:0] t, bit [7:0] p, bit [15:0] b,
			bit [31:0] now, bit [7:0] rp, bit [15:0] rb);
		in_t x;
		x.command = c; x.thread_tag = t; x.thread_priority = p; x.burst_estimate = b;
		x.now_tick = now; x.running_priority = rp; x.running_burst = rb;
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= x;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_command(x);
	endtask

	task automatic send_random();
		int r;
		cmd_e c;
		r = $urandom_range(99);
		c = r < 40 ? CMD_ENQUEUE : r < 70 ? CMD_DEQUEUE : r < 85 ? CMD_CHECK : CMD_AGE;
		tick_now += $urandom_range(3000);
		if ($urandom_range(19) == 0) tick_now = $urandom;
		send_cmd(c, 8'($urandom), 8'($urandom),
			$urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(40)),
			tick_now, 8'($urandom),
			$urandom_range(1) ? 16'($urandom) : 16'($urandom_range(40)));
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(reg_e idx, bit [15:0] v);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		sb.write_reg(idx, v);
	endtask

	initial begin
		sb = new();
		sb.clear();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_cmd(CMD_DEQUEUE, 0, 0, 0, 0, 0, 0);
		send_cmd(CMD_CHECK, 0, 0, 0, 0, 0, 0);
		send_cmd(CMD_AGE, 0, 0, 0, 32'hFFFF_FFFF, 0, 0);
		for (int i = 0; i < 17; i++)
			send_cmd(CMD_ENQUEUE, 8'(i * 15), i[0] ? 8'hFF : 8'(i * 7), i[1] ? 16'hFFFF : 16'd5,
				32'hFFFF_FF00, 0, 0);
		send_cmd(CMD_CHECK, 0, 0, 0, 0, 8'hFF, 16'hFFFF);
		send_cmd(CMD_CHECK, 0, 0, 0, 0, 8'hFF, 16'h0);
		send_cmd(CMD_AGE, 0, 0, 0, 32'h0000_1000, 0, 0);
		for (int i = 0; i < 17; i++) send_cmd(CMD_DEQUEUE, 0, 0, 0, 0, 0, 0);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 73; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 73; end
				default: begin send_idle_pct = 16; recv_stall_pct = 16; end
			endcase
			case (ph)
				0: begin
					write_reg(REG_L1_FLOOR, 16'hFFFF); write_reg(REG_L2_FLOOR, 0);
					write_reg(REG_AGING_WAIT, 1); write_reg(REG_AGING_STEP, 255);
					write_reg(REG_PRIORITY_CAP, 255);
				end
				1: begin
					write_reg(REG_L1_FLOOR, 0); write_reg(REG_L2_FLOOR, 255);
					write_reg(REG_AGING_WAIT, 16'hFFFF); write_reg(REG_AGING_STEP, 0);
					write_reg(REG_PRIORITY_CAP, 0);
				end
				2: begin
					write_reg(REG_L1_FLOOR, 200); write_reg(REG_L2_FLOOR, 60);
					write_reg(REG_AGING_WAIT, 0); write_reg(REG_AGING_STEP, 30);
					write_reg(REG_PRIORITY_CAP, 220);
				end
				default: begin
					write_reg(REG_L1_FLOOR, 16'($urandom));
					write_reg(REG_L2_FLOOR, 16'($urandom_range(120)));
					write_reg(REG_AGING_WAIT, 16'($urandom_range(1, 4000)));
					write_reg(REG_AGING_STEP, 16'($urandom_range(40)));
					write_reg(REG_PRIORITY_CAP, 16'($urandom));
				end
			endcase
			cfg_we <= 0;
			for (int n = 0; n < 85; n++) send_random();
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end
endmodule
`default_nettype wire
